FILE: hdl/hsv_pkg.sv
// Shared constants, sector codes and stage-to-stage types for the HSV to RGB converter.
// Used by every module of the converter; depends on nothing else.

package hsv_pkg;

   localparam int HUE_W = 11;
   localparam int SAT_W = 9;
   localparam int VAL_W = 8;
   localparam int CH_W  = 8;

   // Hue reduction: 1080 = 3 * 360 lifts any 11-bit hue to a positive angle.
   localparam logic [11:0] HUE_OFFSET   = 12'd1080;
   // floor(t / 60) = (t * 2185) >> 17 for every t below 4681.
   localparam logic [11:0] DIV60_MULT   = 12'd2185;
   localparam int          DIV60_SHIFT  = 17;
   localparam logic [5:0]  SECTOR_SIZE  = 6'd60;
   localparam logic [5:0]  SECTOR_COUNT = 6'd6;
   // floor(q / 6) = (q * 43) >> 8 for every q below 128.
   localparam logic [5:0]  DIV6_MULT    = 6'd43;
   localparam int          DIV6_SHIFT   = 8;

   localparam logic [8:0]  SAT_ONE      = 9'd256;
   localparam logic [13:0] FRAC_ONE     = 14'd15360;
   // floor(p / 60) = (p * 17477) >> 20 for every p below 23831.
   localparam logic [14:0] FRAC_DIV_MULT  = 15'd17477;
   localparam int          FRAC_DIV_SHIFT = 20;

   localparam logic [2:0] SECTOR_RED_YELLOW    = 3'd0;
   localparam logic [2:0] SECTOR_YELLOW_GREEN  = 3'd1;
   localparam logic [2:0] SECTOR_GREEN_CYAN    = 3'd2;
   localparam logic [2:0] SECTOR_CYAN_BLUE     = 3'd3;
   localparam logic [2:0] SECTOR_BLUE_MAGENTA  = 3'd4;
   localparam logic [2:0] SECTOR_MAGENTA_RED   = 3'd5;

   typedef struct packed {
      logic               valid;
      logic [2:0]         sector;
      logic [5:0]         rem;
      logic [SAT_W-1:0]   sat;
      logic [VAL_W-1:0]   val;
   } sector_out_type;

   typedef struct packed {
      logic               valid;
      logic [2:0]         sector;
      logic [VAL_W-1:0]   val;
      logic [CH_W-1:0]    x;
      logic [28:0]        y_prod;
      logic [28:0]        z_prod;
   } level_out_type;

endpackage

FILE: hdl/hsv_sector.sv
// Hue reduction stages: splits the hue into sector and remainder and clamps saturation.
// Depends on hsv_pkg.

module hsv_sector (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            in_valid,
   input  logic signed [hsv_pkg::HUE_W-1:0] hue,
   input  logic [hsv_pkg::SAT_W-1:0]       sat,
   input  logic [hsv_pkg::VAL_W-1:0]       val,
   output hsv_pkg::sector_out_type         out
);

   logic [11:0]               t_in;
   logic [23:0]               prod_in;
   logic [hsv_pkg::SAT_W-1:0] sat_in;

   logic                      valid1_ff;
   logic [11:0]               t1_ff;
   logic [23:0]               prod1_ff;
   logic [hsv_pkg::SAT_W-1:0] sat1_ff;
   logic [hsv_pkg::VAL_W-1:0] val1_ff;

   logic [5:0]                quot60;
   logic [11:0]               rem_full;
   logic [11:0]               q6_prod;
   logic [5:0]                sector_full;
   hsv_pkg::sector_out_type   out_in;
   hsv_pkg::sector_out_type   out_ff;

   // The offset keeps the sum positive, so the 12-bit wrap of the sign-extended hue is exact.
   always_comb begin
      t_in    = {hue[hsv_pkg::HUE_W-1], hue} + hsv_pkg::HUE_OFFSET;
      prod_in = 24'(t_in) * 24'(hsv_pkg::DIV60_MULT);
      sat_in  = (sat > hsv_pkg::SAT_ONE) ? hsv_pkg::SAT_ONE : sat;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
      end else begin
         valid1_ff <= in_valid;
      end
      t1_ff    <= t_in;
      prod1_ff <= prod_in;
      sat1_ff  <= sat_in;
      val1_ff  <= val;
   end

   // The number of whole 60-degree steps is below 36; its value mod 6 is the sector.
   always_comb begin
      quot60      = prod1_ff[hsv_pkg::DIV60_SHIFT +: 6];
      rem_full    = t1_ff - 12'(quot60) * 12'(hsv_pkg::SECTOR_SIZE);
      q6_prod     = 12'(quot60) * 12'(hsv_pkg::DIV6_MULT);
      sector_full = quot60 - 6'(q6_prod[hsv_pkg::DIV6_SHIFT +: 3]) * hsv_pkg::SECTOR_COUNT;
      out_in.valid  = valid1_ff;
      out_in.sector = sector_full[2:0];
      out_in.rem    = rem_full[5:0];
      out_in.sat    = sat1_ff;
      out_in.val    = val1_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_ff.valid <= 1'b0;
      end else begin
         out_ff.valid <= out_in.valid;
      end
      out_ff.sector <= out_in.sector;
      out_ff.rem    <= out_in.rem;
      out_ff.sat    <= out_in.sat;
      out_ff.val    <= out_in.val;
   end

   assign out = out_ff;

   a_sector_range: assert property (@(posedge clock) disable iff (reset)
      out_ff.valid |-> (out_ff.sector <= hsv_pkg::SECTOR_MAGENTA_RED &&
                        out_ff.rem < hsv_pkg::SECTOR_SIZE))
      else $error("hue reduction left sector or remainder out of range");

   a_sat_clamped: assert property (@(posedge clock) disable iff (reset)
      out_ff.valid |-> out_ff.sat <= hsv_pkg::SAT_ONE)
      else $error("saturation not clamped to one");

endmodule

FILE: hdl/hsv_level.sv
// Level stages: forms the x, y and z intensity levels through three multiplier stages.
// Depends on hsv_pkg; fed by hsv_sector.

module hsv_level (
   input  logic                     clock,
   input  logic                     reset,
   input  hsv_pkg::sector_out_type  in,
   output hsv_pkg::level_out_type   out
);

   logic [14:0]               sr_prod;
   logic [14:0]               szr_prod;
   logic [14:0]               ny_full;
   logic [14:0]               nz_full;
   logic [8:0]                nx_in;

   logic                      valid3_ff;
   logic [2:0]                sector3_ff;
   logic [hsv_pkg::VAL_W-1:0] val3_ff;
   logic [8:0]                nx3_ff;
   logic [13:0]               ny3_ff;
   logic [13:0]               nz3_ff;

   logic [16:0]               px_in;
   logic [21:0]               py_in;
   logic [21:0]               pz_in;

   logic                      valid4_ff;
   logic [2:0]                sector4_ff;
   logic [hsv_pkg::VAL_W-1:0] val4_ff;
   logic [16:0]               px4_ff;
   logic [21:0]               py4_ff;
   logic [21:0]               pz4_ff;

   hsv_pkg::level_out_type    out_in;
   hsv_pkg::level_out_type    out_ff;

   // Numerators of the three levels; s*rem never exceeds 15360, so they stay non-negative.
   always_comb begin
      sr_prod  = 15'(in.sat) * 15'(in.rem);
      szr_prod = 15'(in.sat) * 15'(hsv_pkg::SECTOR_SIZE - in.rem);
      ny_full  = 15'(hsv_pkg::FRAC_ONE) - sr_prod;
      nz_full  = 15'(hsv_pkg::FRAC_ONE) - szr_prod;
      nx_in    = hsv_pkg::SAT_ONE - in.sat;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid3_ff <= 1'b0;
      end else begin
         valid3_ff <= in.valid;
      end
      sector3_ff <= in.sector;
      val3_ff    <= in.val;
      nx3_ff     <= nx_in;
      ny3_ff     <= ny_full[13:0];
      nz3_ff     <= nz_full[13:0];
   end

   always_comb begin
      px_in = 17'(val3_ff) * 17'(nx3_ff);
      py_in = 22'(val3_ff) * 22'(ny3_ff);
      pz_in = 22'(val3_ff) * 22'(nz3_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid4_ff <= 1'b0;
      end else begin
         valid4_ff <= valid3_ff;
      end
      sector4_ff <= sector3_ff;
      val4_ff    <= val3_ff;
      px4_ff     <= px_in;
      py4_ff     <= py_in;
      pz4_ff     <= pz_in;
   end

   // Division by 15360 is a shift by 8 followed by a reciprocal multiply for the factor 60.
   always_comb begin
      out_in.valid  = valid4_ff;
      out_in.sector = sector4_ff;
      out_in.val    = val4_ff;
      out_in.x      = px4_ff[15:8];
      out_in.y_prod = 29'(py4_ff[21:8]) * 29'(hsv_pkg::FRAC_DIV_MULT);
      out_in.z_prod = 29'(pz4_ff[21:8]) * 29'(hsv_pkg::FRAC_DIV_MULT);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_ff.valid <= 1'b0;
      end else begin
         out_ff.valid <= out_in.valid;
      end
      out_ff.sector <= out_in.sector;
      out_ff.val    <= out_in.val;
      out_ff.x      <= out_in.x;
      out_ff.y_prod <= out_in.y_prod;
      out_ff.z_prod <= out_in.z_prod;
   end

   assign out = out_ff;

   a_x_below_value: assert property (@(posedge clock) disable iff (reset)
      out_ff.valid |-> out_ff.x <= out_ff.val)
      else $error("x level exceeds the value level");

endmodule

FILE: hdl/hsv_route.sv
// Output stage: finishes the y and z levels and routes v, x, y, z to red, green and blue.
// Depends on hsv_pkg; fed by hsv_level.

module hsv_route (
   input  logic                         clock,
   input  logic                         reset,
   input  hsv_pkg::level_out_type       in,
   output logic                         strobe,
   output logic [hsv_pkg::CH_W-1:0]     red,
   output logic [hsv_pkg::CH_W-1:0]     green,
   output logic [hsv_pkg::CH_W-1:0]     blue
);

   logic [hsv_pkg::CH_W-1:0] y_lvl;
   logic [hsv_pkg::CH_W-1:0] z_lvl;
   logic [hsv_pkg::CH_W-1:0] red_in;
   logic [hsv_pkg::CH_W-1:0] green_in;
   logic [hsv_pkg::CH_W-1:0] blue_in;

   logic                     strobe_ff;
   logic [hsv_pkg::CH_W-1:0] red_ff;
   logic [hsv_pkg::CH_W-1:0] green_ff;
   logic [hsv_pkg::CH_W-1:0] blue_ff;

   always_comb begin
      y_lvl = in.y_prod[hsv_pkg::FRAC_DIV_SHIFT +: hsv_pkg::CH_W];
      z_lvl = in.z_prod[hsv_pkg::FRAC_DIV_SHIFT +: hsv_pkg::CH_W];
      unique case (in.sector)
         hsv_pkg::SECTOR_RED_YELLOW: begin
            red_in = in.val;  green_in = z_lvl;  blue_in = in.x;
         end
         hsv_pkg::SECTOR_YELLOW_GREEN: begin
            red_in = y_lvl;   green_in = in.val; blue_in = in.x;
         end
         hsv_pkg::SECTOR_GREEN_CYAN: begin
            red_in = in.x;    green_in = in.val; blue_in = z_lvl;
         end
         hsv_pkg::SECTOR_CYAN_BLUE: begin
            red_in = in.x;    green_in = y_lvl;  blue_in = in.val;
         end
         hsv_pkg::SECTOR_BLUE_MAGENTA: begin
            red_in = z_lvl;   green_in = in.x;   blue_in = in.val;
         end
         default: begin
            red_in = in.val;  green_in = in.x;   blue_in = y_lvl;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= in.valid;
      end
      red_ff   <= red_in;
      green_ff <= green_in;
      blue_ff  <= blue_in;
   end

   assign strobe = strobe_ff;
   assign red    = red_ff;
   assign green  = green_ff;
   assign blue   = blue_ff;

   // One channel always carries the full value level.
   a_value_present: assert property (@(posedge clock) disable iff (reset)
      in.valid |=> (red_ff == $past(in.val) || green_ff == $past(in.val) ||
                    blue_ff == $past(in.val)))
      else $error("no channel carries the value level");

endmodule

FILE: hdl/hsv_to_rgb_converter_top.sv
// Top level of the HSV to RGB converter: command port in, strobed result port out.
// Depends on hsv_pkg, hsv_sector, hsv_level and hsv_route.
//
//   Channel   Ports                                              Transfer when
//   request   start, busy, req_hue_degrees, req_saturation,       start && !busy
//             req_value_level
//   response  rsp_strobe, rsp_red, rsp_green, rsp_blue            rsp_strobe
//
// Six register stages: hue reduction (2), level multipliers (3) and channel routing (1).
// A request may be given in every cycle; its result passes through hue reduction, the level multipliers and routing.
// The multipliers are fully pipelined, so busy stays low and one colour leaves per cycle.
// Synchronous reset clears the valid bits of all stages; data registers are not reset.
// It is up to the receiver that it takes every result in its strobe cycle; the block does not enforce it.

module hsv_to_rgb_converter_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic signed [hsv_pkg::HUE_W-1:0]  req_hue_degrees,
   input  logic [hsv_pkg::SAT_W-1:0]         req_saturation,
   input  logic [hsv_pkg::VAL_W-1:0]         req_value_level,
   output logic                              rsp_strobe,
   output logic [hsv_pkg::CH_W-1:0]          rsp_red,
   output logic [hsv_pkg::CH_W-1:0]          rsp_green,
   output logic [hsv_pkg::CH_W-1:0]          rsp_blue
);

   logic                    req_accept;
   hsv_pkg::sector_out_type sector_out;
   hsv_pkg::level_out_type  level_out;

   assign busy       = 1'b0;
   assign req_accept = start && !busy;

   hsv_sector u_sector (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_accept),
      .hue      (req_hue_degrees),
      .sat      (req_saturation),
      .val      (req_value_level),
      .out      (sector_out)
   );

   hsv_level u_level (
      .clock (clock),
      .reset (reset),
      .in    (sector_out),
      .out   (level_out)
   );

   hsv_route u_route (
      .clock  (clock),
      .reset  (reset),
      .in     (level_out),
      .strobe (rsp_strobe),
      .red    (rsp_red),
      .green  (rsp_green),
      .blue   (rsp_blue)
   );

   a_latency: assert property (@(posedge clock) disable iff (reset)
      req_accept |-> ##6 rsp_strobe)
      else $error("accepted request produced no result after six cycles");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(req_accept, 6))
      else $error("result strobe without a matching request");

   a_grey: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_saturation == '0) |->
         ##6 (rsp_red == rsp_green && rsp_green == rsp_blue))
      else $error("zero saturation did not give grey");

endmodule
